[design/pdbmc_pkg.sv]
package pdbmc_pkg;

	localparam int PREAMBLE_BITS    = 64;
	localparam int CELLS_PER_RESULT = 16;

	localparam int PRE_CHUNKS     = (PREAMBLE_BITS + CELLS_PER_RESULT - 1) / CELLS_PER_RESULT;
	localparam int PRE_LAST_CELLS = PREAMBLE_BITS - (PRE_CHUNKS - 1) * CELLS_PER_RESULT;
	localparam int CHUNK_W        = (PRE_CHUNKS > 1) ? $clog2(PRE_CHUNKS) : 1;
	localparam logic CELLS_ODD    = 1'((CELLS_PER_RESULT % 2) == 1);

	localparam int MAX_CELLS   = 16;
	localparam int GROUP_CELLS = 5;
	localparam int NUM_OS_CODES = 4;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [4:0] K_SYNC1 = 5'h18;
	localparam logic [4:0] K_SYNC2 = 5'h11;
	localparam logic [4:0] K_RST1  = 5'h07;
	localparam logic [4:0] K_RST2  = 5'h19;
	localparam logic [4:0] K_SYNC3 = 5'h06;
	localparam logic [4:0] K_EOP   = 5'h0D;
	localparam logic [4:0] DATA_0  = 5'h1E;

	localparam logic [7:0] TGT_LIMIT = 8'd8;

	localparam logic [4:0] ENC_4B5B [16] = '{
		5'h1E, 5'h09, 5'h14, 5'h15, 5'h0A, 5'h0B, 5'h0E, 5'h0F,
		5'h12, 5'h13, 5'h16, 5'h17, 5'h1A, 5'h1B, 5'h1C, 5'h1D
	};

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] half_levels;
		logic [4:0]  cell_count;
		logic        long_cell;
		logic        frame_end;
		logic        run_last;
	} out_item_t;

	// one classified byte: target (ordered set) or payload (two data groups)
	typedef struct packed {
		logic                          is_target;
		logic                          last;
		logic [NUM_OS_CODES-1:0][4:0] codes;
	} cmd_t;

	typedef enum logic [1:0] {
		PH_PRE,
		PH_GRP,
		PH_EOP,
		PH_LONG
	} phase_t;

	function automatic logic [NUM_OS_CODES-1:0][4:0] os_codes(input logic [2:0] tgt);
		logic [NUM_OS_CODES-1:0][4:0] c;
		unique case (tgt)
			3'd1:    c = {K_SYNC2, K_SYNC1, K_SYNC1, K_SYNC1};
			3'd2:    c = {K_SYNC3, K_SYNC3, K_SYNC1, K_SYNC1};
			3'd3:    c = {K_SYNC3, K_SYNC1, K_SYNC3, K_SYNC1};
			3'd4:    c = {K_SYNC3, K_RST2, K_RST2, K_SYNC1};
			3'd5:    c = {K_SYNC2, K_SYNC3, K_RST2, K_SYNC1};
			3'd6:    c = {K_RST2, K_RST1, K_RST1, K_RST1};
			3'd7:    c = {K_SYNC3, K_RST1, K_SYNC1, K_RST1};
			default: c = {DATA_0, DATA_0, DATA_0, DATA_0};
		endcase
		return c;
	endfunction

	// BMC: cell opens at the line level, a one flips at mid-cell, every cell
	// closes with a flip. Cells at or above n stay zero.
	function automatic logic [32:0] bmc_encode(input logic lv, input logic [MAX_CELLS-1:0] bits,
			input logic [4:0] n);
		logic [31:0] lvls;
		logic        l;
		lvls = '0;
		l    = lv;
		for (int j = 0; j < MAX_CELLS; j++) begin
			if (5'(j) < n) begin
				lvls[2*j] = l;
				if (!bits[j])
					l = ~l;
				lvls[2*j+1] = ~l;
			end
		end
		return {l, lvls};
	endfunction

endpackage

[design/pdbmc_front.sv]
module pdbmc_front import pdbmc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     push,
	output cmd_t     cmd,
	input  logic     fifo_ready
);

	logic at_start_q;

	assign in_ready = fifo_ready;
	assign push     = in_valid & fifo_ready;

	always_comb begin
		cmd.is_target = at_start_q;
		cmd.last      = in_data.frame_last;
		if (at_start_q) begin
			// unknown targets fall back to four data-zero groups
			if (in_data.frame_byte < TGT_LIMIT)
				cmd.codes = os_codes(in_data.frame_byte[2:0]);
			else
				cmd.codes = os_codes(3'd0);
		end else begin
			cmd.codes = {5'd0, 5'd0, ENC_4B5B[in_data.frame_byte[7:4]],
				ENC_4B5B[in_data.frame_byte[3:0]]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			at_start_q <= 1'b1;
		else if (push)
			at_start_q <= in_data.frame_last;
	end

endmodule

[design/pdbmc_cmd_fifo.sv]
module pdbmc_cmd_fifo import pdbmc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic ready,
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic pop
);

	cmd_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign ready     = count_q != FIFO_CNT_W'(FIFO_DEPTH);
	assign cmd_valid = count_q != '0;
	assign cmd       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[design/pdbmc_back.sv]
module pdbmc_back import pdbmc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(PRE_CHUNKS - 1);

	phase_t               phase_q, phase_d;
	logic                 busy_q, busy_d;
	logic [CHUNK_W-1:0]   chunk_q, chunk_d;
	logic [1:0]           grp_q, grp_d;
	logic                 lv_q, lv_d;
	cmd_t                 cmd_q, cmd_d;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic                 advance;
	logic                 emit;
	logic                 final_res;
	logic [MAX_CELLS-1:0] bits;
	logic [MAX_CELLS-1:0] pre_bits;
	logic [4:0]           ncells;
	logic                 is_long;
	logic [32:0]          enc;
	logic [1:0]           last_grp;

	assign advance   = !out_valid_q || out_ready;
	assign emit      = busy_q && advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign last_grp  = cmd_q.is_target ? 2'd3 : 2'd1;

	always_comb begin
		for (int j = 0; j < MAX_CELLS; j++)
			pre_bits[j] = ((j % 2) == 1) ^ (chunk_q[0] & CELLS_ODD);
	end

	always_comb begin
		phase_d   = phase_q;
		chunk_d   = chunk_q;
		grp_d     = grp_q;
		bits      = '0;
		ncells    = 5'(GROUP_CELLS);
		is_long   = 1'b0;
		final_res = 1'b0;
		unique case (phase_q)
			PH_PRE: begin
				bits = pre_bits;
				if (chunk_q == LAST_CHUNK) begin
					ncells  = 5'(PRE_LAST_CELLS);
					phase_d = PH_GRP;
					grp_d   = '0;
				end else begin
					ncells  = 5'(CELLS_PER_RESULT);
					chunk_d = chunk_q + 1'b1;
				end
			end
			PH_GRP: begin
				bits = MAX_CELLS'(cmd_q.codes[grp_q]);
				grp_d = grp_q + 1'b1;
				if (grp_q == last_grp) begin
					if (cmd_q.last)
						phase_d = PH_EOP;
					else
						final_res = 1'b1;
				end
			end
			PH_EOP: begin
				bits    = MAX_CELLS'(K_EOP);
				phase_d = PH_LONG;
			end
			PH_LONG: begin
				ncells    = 5'd1;
				is_long   = 1'b1;
				final_res = 1'b1;
			end
			default: ;
		endcase
		enc = bmc_encode(lv_q, bits, ncells);

		if (!emit) begin
			phase_d = phase_q;
			chunk_d = chunk_q;
			grp_d   = grp_q;
		end
		lv_d   = emit ? enc[32] : lv_q;
		busy_d = busy_q && !(emit && final_res);
		cmd_d  = cmd_q;
		pop    = cmd_valid && (!busy_q || (emit && final_res));
		if (pop) begin
			cmd_d   = cmd;
			busy_d  = 1'b1;
			phase_d = cmd.is_target ? PH_PRE : PH_GRP;
			chunk_d = '0;
			grp_d   = '0;
			if (cmd.is_target)
				lv_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PRE;
			busy_q      <= 1'b0;
			chunk_q     <= '0;
			grp_q       <= '0;
			lv_q        <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			busy_q  <= busy_d;
			chunk_q <= chunk_d;
			grp_q   <= grp_d;
			lv_q    <= lv_d;
			if (advance)
				out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		if (emit) begin
			out_q.half_levels <= enc[31:0];
			out_q.cell_count  <= ncells;
			out_q.long_cell   <= is_long;
			out_q.frame_end   <= is_long;
			out_q.run_last    <= final_res;
		end
	end

endmodule

[design/pd_bmc_frame_transmitter.sv]
// BMC frame transmitter with 4b5b line coding.
// Input channel (in_valid/in_ready/in_data): one frame byte per transfer; the
// first byte of a frame is the target code, frame_last flags the last byte.
// Output channel (out_valid/out_ready/out_data): chunks of BMC bit cells as
// packed half-period levels, up to 16 cells per transfer.
// A target byte yields the preamble in chunks (4 at default sizes) and four
// ordered-set groups; a payload byte yields two code groups; a flagged byte
// adds the EOP group and a single long cell (long_cell and frame_end set).
// run_last marks the last result of each byte.
// A byte is written into the command queue, popped into the sequencer's
// command register; its first result is then held in the output register.
// The sequencer gives one result per cycle while the receiver takes them;
// a two-entry command queue lets the byte classifier run ahead of it.
// Reset puts the line level high and expects a target byte next.
// When the receiver stalls the output register holds; the queue fills, then
// in_ready drops until results move again.
module pd_bmc_frame_transmitter import pdbmc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic push;
	cmd_t push_cmd;
	logic fifo_ready;
	logic cmd_valid;
	cmd_t cmd;
	logic pop;

	pdbmc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push       (push),
		.cmd        (push_cmd),
		.fifo_ready (fifo_ready)
	);

	pdbmc_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.ready     (fifo_ready),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.pop       (pop)
	);

	pdbmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef SYNTH
	a_long_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.long_cell |->
			out_data.frame_end && out_data.run_last && out_data.cell_count == 5'd1)
		else $error("long cell without frame end");

	a_end_is_long: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |-> out_data.long_cell)
		else $error("frame end without long cell");

	a_cell_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.cell_count != 5'd0
			&& out_data.cell_count <= 5'(CELLS_PER_RESULT))
		else $error("cell count out of range");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cmd_valid)
		else $error("command popped from empty queue");
`endif

endmodule

[sim/pd_bmc_frame_transmitter_tb.sv]
`timescale 1ns / 100ps

module pd_bmc_frame_transmitter_tb;
	import pdbmc_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int MAX_REPORTS    = 10;
	localparam int NUM_BYTES      = 110;

	typedef enum logic [7:0] {
		TGT_NONE       = 8'd0,
		TGT_SOP        = 8'd1,
		TGT_SOP_P      = 8'd2,
		TGT_SOP_PP     = 8'd3,
		TGT_SOP_P_DBG  = 8'd4,
		TGT_SOP_PP_DBG = 8'd5,
		TGT_HARD_RST   = 8'd6,
		TGT_CABLE_RST  = 8'd7
	} target_e;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_LONG
	} rx_mode_e;

	// ordered sets in line order; unknown targets fall back to entry 0
	localparam logic [4:0] TGT_SETS [8][4] = '{
		'{DATA_0,  DATA_0,  DATA_0,  DATA_0},
		'{K_SYNC1, K_SYNC1, K_SYNC1, K_SYNC2},
		'{K_SYNC1, K_SYNC1, K_SYNC3, K_SYNC3},
		'{K_SYNC1, K_SYNC3, K_SYNC1, K_SYNC3},
		'{K_SYNC1, K_RST2,  K_RST2,  K_SYNC3},
		'{K_SYNC1, K_RST2,  K_SYNC3, K_SYNC2},
		'{K_RST1,  K_RST1,  K_RST1,  K_RST2},
		'{K_RST1,  K_SYNC1, K_RST1,  K_SYNC3}
	};

	localparam logic [7:0] WALK_PAYLOAD [10] = '{
		8'h00, 8'hFF, 8'h10, 8'h32, 8'h54, 8'h76, 8'h98, 8'hBA, 8'hDC, 8'hFE
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	pd_bmc_frame_transmitter u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- BMC encoder model
	logic        line_lvl = 1'b1;
	logic        next_is_target = 1'b1;
	logic [31:0] cell_levels = '0;
	int          cell_cnt = 0;
	out_item_t   byte_chunks[$];
	out_item_t   expected_chunks[$];

	task automatic add_cell(input logic b);
		logic first;
		first = line_lvl;
		if (!b) line_lvl = ~line_lvl;
		cell_levels[2*cell_cnt]   = first;
		cell_levels[2*cell_cnt+1] = ~line_lvl;
		cell_cnt++;
	endtask

	task automatic close_chunk(input logic is_long);
		out_item_t c;
		c.half_levels = cell_levels;
		c.cell_count  = 5'(cell_cnt);
		c.long_cell   = is_long;
		c.frame_end   = is_long;
		c.run_last    = 1'b0;
		byte_chunks.push_back(c);
		cell_levels = '0;
		cell_cnt    = 0;
	endtask

	task automatic send_group(input logic [4:0] code);
		for (int i = 0; i < GROUP_CELLS; i++)
			add_cell(code[i]);
		close_chunk(1'b0);
	endtask

	task automatic predict_byte(input in_item_t it);
		int        tgt_idx;
		out_item_t c;
		byte_chunks = {};
		cell_levels = '0;
		cell_cnt    = 0;
		if (next_is_target) begin
			tgt_idx  = (it.frame_byte < TGT_LIMIT) ? int'(it.frame_byte) : 0;
			line_lvl = 1'b1;
			for (int i = 0; i < PREAMBLE_BITS; i++) begin
				add_cell(1'(i & 1));
				if (cell_cnt >= CELLS_PER_RESULT) close_chunk(1'b0);
			end
			if (cell_cnt > 0) close_chunk(1'b0);
			for (int i = 0; i < NUM_OS_CODES; i++)
				send_group(TGT_SETS[tgt_idx][i]);
			next_is_target = 1'b0;
		end else begin
			send_group(ENC_4B5B[it.frame_byte[3:0]]);
			send_group(ENC_4B5B[it.frame_byte[7:4]]);
		end
		if (it.frame_last) begin
			send_group(K_EOP);
			add_cell(1'b0);
			close_chunk(1'b1);
			next_is_target = 1'b1;
		end
		c = byte_chunks.pop_back();
		c.run_last = 1'b1;
		byte_chunks.push_back(c);
		foreach (byte_chunks[i])
			expected_chunks.push_back(byte_chunks[i]);
	endtask

	// ---------------------------------------------------------------- checking
	int mismatches = 0;
	int accepted_bytes = 0;
	int idle_cycles = 0;

	task automatic check_chunk(input out_item_t got);
		out_item_t want;
		if (expected_chunks.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: unexpected result levels %h cells %0d long %b end %b last %b",
					$time, got.half_levels, got.cell_count, got.long_cell, got.frame_end,
					got.run_last);
			return;
		end
		want = expected_chunks.pop_front();
		if (got.half_levels !== want.half_levels || got.cell_count !== want.cell_count ||
				got.long_cell !== want.long_cell || got.frame_end !== want.frame_end ||
				got.run_last !== want.run_last) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("%0t: expected levels %h cells %0d long %b end %b last %b",
					$time, want.half_levels, want.cell_count, want.long_cell, want.frame_end,
					want.run_last);
				$display("%0t: got      levels %h cells %0d long %b end %b last %b",
					$time, got.half_levels, got.cell_count, got.long_cell, got.frame_end,
					got.run_last);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_byte(in_data);
				accepted_bytes++;
			end
			if (out_valid && out_ready) check_chunk(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- byte driver
	in_item_t pending_bytes[$];
	int       burst_left = 0;
	int       gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				in_data  <= pending_bytes.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- result sink
	rx_mode_e    rx_mode = RX_OPEN;
	int unsigned mode_left = 0;
	int unsigned rx_phase = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   = rx_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end else begin
				mode_left--;
			end
			rx_phase++;
			case (rx_mode)
				RX_OPEN:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= (rx_phase % 7) < 2;
				default:   out_ready <= (rx_phase % 24) >= 18;
			endcase
		end
	end

	// ---------------------------------------------------------------- stimulus
	task automatic queue_byte(input logic [7:0] b, input logic last);
		pending_bytes.push_back(in_item_t'{frame_byte: b, frame_last: last});
	endtask

	initial begin
		int          total_bytes;
		int          n_pay;
		int unsigned pick;
		logic [7:0]  tgt;

		// SOP frame walking nibble values through the 4b5b table
		queue_byte(TGT_SOP, 1'b0);
		foreach (WALK_PAYLOAD[i])
			queue_byte(WALK_PAYLOAD[i], i == 9);
		// remaining ordered sets, each as a bare target flagged last
		queue_byte(TGT_SOP_P, 1'b1);
		queue_byte(TGT_SOP_PP, 1'b1);
		queue_byte(TGT_SOP_P_DBG, 1'b1);
		queue_byte(TGT_SOP_PP_DBG, 1'b1);
		queue_byte(TGT_HARD_RST, 1'b1);
		queue_byte(TGT_CABLE_RST, 1'b1);
		// unknown targets: zero, just above the range, all ones
		queue_byte(TGT_NONE, 1'b0);
		queue_byte(8'hA5, 1'b1);
		queue_byte(TGT_LIMIT, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h5A, 1'b1);

		while (pending_bytes.size() < NUM_BYTES) begin
			pick = $urandom_range(0, 9);
			if (pick < 8)
				tgt = 8'($urandom_range(TGT_SOP, TGT_CABLE_RST));
			else if (pick == 8)
				tgt = TGT_NONE;
			else
				tgt = 8'($urandom_range(8, 255));
			n_pay = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 6);
			// trim the final frame to the byte budget
			if (pending_bytes.size() + 1 + n_pay > NUM_BYTES)
				n_pay = NUM_BYTES - pending_bytes.size() - 1;
			queue_byte(tgt, n_pay == 0);
			for (int k = 1; k <= n_pay; k++)
				queue_byte(8'($urandom), k == n_pay);
		end
		total_bytes = pending_bytes.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (accepted_bytes < total_bytes || expected_chunks.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && expected_chunks.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
